>>> sv/tps_pkg.sv
package tps_pkg;

    // Default phase width, Q3.12 radians
    localparam int unsigned PHASE_WIDTH_DEF = 16;
    localparam int unsigned NUM_LANES       = 4;
    localparam int unsigned COEF_WIDTH      = 4;
    localparam int unsigned MASK_WIDTH      = 4;

    typedef logic [MASK_WIDTH-1:0]  mask_t;
    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic [NUM_LANES-1:0][COEF_WIDTH-1:0] coef_row_t;
    typedef logic [1:0] lane_idx_t;

    typedef enum logic [2:0] {
        FORM_NONE = 3'd0,
        FORM_ALL  = 3'd1,
        FORM_NO1  = 3'd2,
        FORM_NO4  = 3'd3,
        FORM_NO2  = 3'd4,
        FORM_NO3  = 3'd5
    } formula_t;

    // Working-transmitter masks, bit 3 is T1 through bit 0 is T4
    localparam mask_t MASK_RESET = 4'b1111;
    localparam mask_t MASK_ALL   = 4'b1111;
    localparam mask_t MASK_NO1   = 4'b0111;
    localparam mask_t MASK_NO4   = 4'b1110;
    localparam mask_t MASK_NO2   = 4'b1011;
    localparam mask_t MASK_NO3   = 4'b1101;
    localparam mask_t MASK_ZERO  = 4'b0000;

    // Weights in units of 1/4, [row][column]
    localparam coef_t COEF_ALL [4][4] = '{
        '{ 4'sd3,  4'sd2, -4'sd1,  4'sd0},
        '{ 4'sd1,  4'sd2,  4'sd1,  4'sd0},
        '{ 4'sd0,  4'sd1,  4'sd2,  4'sd1},
        '{ 4'sd0, -4'sd1,  4'sd2,  4'sd3}
    };
    localparam coef_t COEF_NO1 [4][4] = '{
        '{ 4'sd0,  4'sd5,  4'sd2, -4'sd3},
        '{ 4'sd0,  4'sd3,  4'sd2, -4'sd1},
        '{ 4'sd0,  4'sd1,  4'sd2,  4'sd1},
        '{ 4'sd0, -4'sd1,  4'sd2,  4'sd3}
    };
    localparam coef_t COEF_NO4 [4][4] = '{
        '{ 4'sd3,  4'sd2, -4'sd1,  4'sd0},
        '{ 4'sd1,  4'sd2,  4'sd1,  4'sd0},
        '{-4'sd1,  4'sd2,  4'sd3,  4'sd0},
        '{-4'sd3,  4'sd2,  4'sd5,  4'sd0}
    };
    localparam coef_t COEF_NO2 [4][4] = '{
        '{ 4'sd5,  4'sd0, -4'sd3,  4'sd2},
        '{ 4'sd3,  4'sd0, -4'sd1,  4'sd2},
        '{ 4'sd1,  4'sd0,  4'sd1,  4'sd2},
        '{-4'sd1,  4'sd0,  4'sd3,  4'sd2}
    };
    localparam coef_t COEF_NO3 [4][4] = '{
        '{ 4'sd2,  4'sd3,  4'sd0, -4'sd1},
        '{ 4'sd2,  4'sd1,  4'sd0,  4'sd1},
        '{ 4'sd2, -4'sd1,  4'sd0,  4'sd3},
        '{-4'sd2, -4'sd3,  4'sd0,  4'sd5}
    };

    localparam coef_t COEF_UNIT = 4'sd4;
    localparam coef_t COEF_ZERO = 4'sd0;

    // Decode the mask into the formula in use
    function automatic formula_t formula_of(mask_t mask);
        formula_t f;
        unique case (mask)
            MASK_ALL: f = FORM_ALL;
            MASK_NO1: f = FORM_NO1;
            MASK_NO4: f = FORM_NO4;
            MASK_NO2: f = FORM_NO2;
            MASK_NO3: f = FORM_NO3;
            default:  f = FORM_NONE;
        endcase
        return f;
    endfunction

    // Weights of one output row; element j weighs phase j+1
    function automatic coef_row_t coef_row(formula_t f, mask_t mask, lane_idx_t row);
        coef_row_t r;
        r = '0;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            unique case (f)
                FORM_ALL: r[j] = COEF_ALL[row][j];
                FORM_NO1: r[j] = COEF_NO1[row][j];
                FORM_NO4: r[j] = COEF_NO4[row][j];
                FORM_NO2: r[j] = COEF_NO2[row][j];
                FORM_NO3: r[j] = COEF_NO3[row][j];
                default:  r[j] = COEF_ZERO;
            endcase
        end
        // Identity for zero mask, pass-through or zero otherwise
        if (f == FORM_NONE)
        begin
            if ((mask == MASK_ZERO) || mask[2'd3 - row])
                r[row] = COEF_UNIT;
        end
        return r;
    endfunction

endpackage

>>> sv/tps_if.sv
interface tps_in_if #(
    parameter int unsigned PHASE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [PHASE_WIDTH-1:0] phase_1;
    logic signed [PHASE_WIDTH-1:0] phase_2;
    logic signed [PHASE_WIDTH-1:0] phase_3;
    logic signed [PHASE_WIDTH-1:0] phase_4;

    modport source (output valid, output phase_1, output phase_2, output phase_3,
                    output phase_4, input ready);
    modport sink   (input valid, input phase_1, input phase_2, input phase_3,
                    input phase_4, output ready);
endinterface

interface tps_out_if #(
    parameter int unsigned PHASE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [PHASE_WIDTH-1:0] sym_phase_1;
    logic signed [PHASE_WIDTH-1:0] sym_phase_2;
    logic signed [PHASE_WIDTH-1:0] sym_phase_3;
    logic signed [PHASE_WIDTH-1:0] sym_phase_4;
    logic [2:0]                    formula_code;

    modport source (output valid, output sym_phase_1, output sym_phase_2,
                    output sym_phase_3, output sym_phase_4, output formula_code,
                    input ready);
    modport sink   (input valid, input sym_phase_1, input sym_phase_2,
                    input sym_phase_3, input sym_phase_4, input formula_code,
                    output ready);
endinterface

>>> sv/tps_lane.sv
module tps_lane #(
    parameter int unsigned PHASE_WIDTH = 16
) (
    input  logic [tps_pkg::NUM_LANES-1:0][PHASE_WIDTH-1:0] phases,
    input  tps_pkg::coef_row_t                             coefs,
    output logic [PHASE_WIDTH-1:0]                         sym
);
    import tps_pkg::*;

    localparam int unsigned PROD_WIDTH = PHASE_WIDTH + COEF_WIDTH;
    localparam int unsigned SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int unsigned Q_WIDTH    = SUM_WIDTH - 2;

    logic signed [PROD_WIDTH-1:0] prod [NUM_LANES];
    logic signed [SUM_WIDTH-1:0]  sum;
    logic signed [SUM_WIDTH-1:0]  biased;
    logic signed [Q_WIDTH-1:0]    quot;
    logic                         fits;

    // Weigh each phase by its quarter-step coefficient
    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            prod[j] = $signed(phases[j]) * $signed(coefs[j]);
        end
    end

    // Accumulate in quarter LSBs
    always_comb
    begin
        sum = '0;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            sum = sum + SUM_WIDTH'(prod[j]);
        end
    end

    // Round to nearest, ties toward plus infinity
    assign biased = sum + SUM_WIDTH'(2);
    assign quot   = biased[SUM_WIDTH-1:2];

    // Saturate to the phase range
    assign fits = (quot[Q_WIDTH-1:PHASE_WIDTH-1] == '0) ||
                  (quot[Q_WIDTH-1:PHASE_WIDTH-1] == '1);

    always_comb
    begin
        if (fits)
            sym = quot[PHASE_WIDTH-1:0];
        else
            sym = {quot[Q_WIDTH-1], {(PHASE_WIDTH-1){~quot[Q_WIDTH-1]}}};
    end

endmodule

>>> sv/tps_merge.sv
module tps_merge #(
    parameter int unsigned PHASE_WIDTH = 16
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [tps_pkg::NUM_LANES-1:0][PHASE_WIDTH-1:0] lane_sym,
    input  tps_pkg::formula_t                              formula,
    tps_out_if.source                                      sym_out
);
    import tps_pkg::*;

    logic                                    valid_reg;
    logic                                    valid_next;
    logic [NUM_LANES-1:0][PHASE_WIDTH-1:0]   sym_reg;
    formula_t                                formula_reg;
    logic                                    load;

    // Take a new transfer whenever the output slot is free or draining
    assign in_ready = !valid_reg || sym_out.ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (sym_out.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the lane results together with the formula code
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sym_reg     <= lane_sym;
            formula_reg <= formula;
        end
    end

    assign sym_out.valid        = valid_reg;
    assign sym_out.sym_phase_1  = sym_reg[0];
    assign sym_out.sym_phase_2  = sym_reg[1];
    assign sym_out.sym_phase_3  = sym_reg[2];
    assign sym_out.sym_phase_4  = sym_reg[3];
    assign sym_out.formula_code = formula_reg;

endmodule

>>> sv/transmitter_phase_symmetrizer_unit.sv
// Transmitter phase symmetrizer.
//
// phase_in carries one set of four signed phases per transfer (valid/ready);
// sym_out returns the four symmetrized, saturated phases and the formula
// code. cfg_we/cfg_wdata write the 4-bit working-transmitter mask (bit 3 is
// T1, bit 0 is T4); write it only while no transfer is in flight.
//
// Four lanes, one per output row, form the weighted sums side by side from
// quarter-step weights; one output register merges them with the code.
// Results are registered: valid in the cycle after the input transfer;
// with no stall, one phase set is taken every cycle (single register stage).
//
// Reset clears the output register's valid flag and sets the mask to all
// four transmitters working. When the receiver stalls, the held result
// stays put and phase_in drops ready until the result is taken; a result
// taken in the same cycle frees the slot for a new transfer at once.
module transmitter_phase_symmetrizer_unit #(
    parameter int unsigned PHASE_WIDTH = tps_pkg::PHASE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tps_pkg::MASK_WIDTH-1:0] cfg_wdata,
    tps_in_if.sink                      phase_in,
    tps_out_if.source                   sym_out
);
    import tps_pkg::*;

    mask_t                                 working_mask_reg;
    mask_t                                 working_mask_next;
    formula_t                              formula;
    logic [NUM_LANES-1:0][PHASE_WIDTH-1:0] phases;
    logic [NUM_LANES-1:0][PHASE_WIDTH-1:0] lane_sym;
    logic                                  in_ready;

    // Hold the mask until written
    assign working_mask_next = cfg_we ? cfg_wdata : working_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            working_mask_reg <= MASK_RESET;
        else
            working_mask_reg <= working_mask_next;
    end

    assign formula = formula_of(working_mask_reg);

    assign phases[0] = phase_in.phase_1;
    assign phases[1] = phase_in.phase_2;
    assign phases[2] = phase_in.phase_3;
    assign phases[3] = phase_in.phase_4;

    // One lane per output row
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        tps_lane #(
            .PHASE_WIDTH (PHASE_WIDTH)
        ) u_lane (
            .phases (phases),
            .coefs  (coef_row(formula, working_mask_reg, lane_idx_t'(i))),
            .sym    (lane_sym[i])
        );
    end

    tps_merge #(
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (phase_in.valid),
        .in_ready (in_ready),
        .lane_sym (lane_sym),
        .formula  (formula),
        .sym_out  (sym_out)
    );

    assign phase_in.ready = in_ready;

endmodule
